@@ rtl/smeu_pkg.sv @@
// ============================================================================
// smeu_pkg: shared definitions for the stack machine execute unit
// Sizes, field widths, opcodes, status codes and the cell control types used
// by the data stack and return stack cell chains.
// ============================================================================
package smeu_pkg;

    // Storage sizes
    localparam int STACK_DEPTH = 64;
    localparam int VAR_COUNT   = 64;
    localparam int CALL_DEPTH  = 32;
    localparam int PROG_DEPTH  = 1024;

    // Field widths
    localparam int WORD_W  = 32;
    localparam int IP_W    = 11;
    localparam int ACT_W   = 4;
    localparam int VIDX_W  = 6;
    localparam int TGT_W   = 10;
    localparam int STAT_W  = 3;

    // Derived widths
    localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);
    localparam int RDEPTH_W = $clog2(CALL_DEPTH + 1);
    localparam int VAR_AW   = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IP_W-1:0]   ip_t;

    localparam ip_t IP_MAX = '1;

    // Opcodes
    localparam logic [ACT_W-1:0] OP_PUSH  = 4'd0;
    localparam logic [ACT_W-1:0] OP_ADD   = 4'd1;
    localparam logic [ACT_W-1:0] OP_SUB   = 4'd2;
    localparam logic [ACT_W-1:0] OP_MUL   = 4'd3;
    localparam logic [ACT_W-1:0] OP_STORE = 4'd4;
    localparam logic [ACT_W-1:0] OP_LOAD  = 4'd5;
    localparam logic [ACT_W-1:0] OP_IF    = 4'd6;
    localparam logic [ACT_W-1:0] OP_GOTO  = 4'd7;
    localparam logic [ACT_W-1:0] OP_FUNC  = 4'd8;
    localparam logic [ACT_W-1:0] OP_CALL  = 4'd9;
    localparam logic [ACT_W-1:0] OP_RET   = 4'd10;
    localparam logic [ACT_W-1:0] OP_PRINT = 4'd11;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STAT_W-1:0] ST_VAR_UNK   = 3'd3;
    localparam logic [STAT_W-1:0] ST_LABEL_UNK = 3'd4;
    localparam logic [STAT_W-1:0] ST_RET_EMPTY = 3'd5;
    localparam logic [STAT_W-1:0] ST_BAD_OP    = 3'd6;
    localparam logic [STAT_W-1:0] ST_HALTED    = 3'd7;

    // Stack movement for one step: merge pops two and pushes one
    typedef enum logic [1:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP,
        STK_MERGE
    } stk_op_t;

    // Per-cell load select
    typedef struct packed {
        logic take_up;
        logic take_down;
    } cell_ctl_t;

    // Add a small step to a pointer, saturating at the all-ones value
    function automatic ip_t sat_inc(input ip_t v, input logic [1:0] n);
        logic [IP_W:0] s;
        s = {1'b0, v} + (IP_W + 1)'(n);
        return s[IP_W] ? IP_MAX : s[IP_W-1:0];
    endfunction

endpackage

@@ rtl/smeu_if.sv @@
// ============================================================================
// smeu_if: word channels of the stack machine execute unit
// Instruction channel and result channel, each with valid, ready and payload.
// ============================================================================
interface smeu_instr_if;
    import smeu_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic signed [WORD_W-1:0] immediate;
    logic [VIDX_W-1:0]   var_index;
    logic [TGT_W-1:0]    target;
    logic                target_found;

    modport source (
        output valid, action, immediate, var_index, target, target_found,
        input  ready
    );

    modport sink (
        input  valid, action, immediate, var_index, target, target_found,
        output ready
    );
endinterface

interface smeu_result_if;
    import smeu_pkg::*;

    logic                valid;
    logic                ready;
    logic [IP_W-1:0]     next_ip;
    logic signed [WORD_W-1:0] top_value;
    logic                top_valid;
    logic                print_valid;
    logic [STAT_W-1:0]   status;
    logic                done_res;

    modport source (
        output valid, next_ip, top_value, top_valid, print_valid, status, done_res,
        input  ready
    );

    modport sink (
        input  valid, next_ip, top_value, top_valid, print_valid, status, done_res,
        output ready
    );
endinterface

@@ rtl/smeu_ram.sv @@
// ============================================================================
// smeu_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ============================================================================
module smeu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                              clk,
    input  logic                                              we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]        waddr,
    input  logic [WIDTH-1:0]                                  wdata,
    input  logic                                              re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]        raddr,
    output logic [WIDTH-1:0]                                  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/smeu_data_cell.sv @@
// ============================================================================
// smeu_data_cell: one entry of the data stack chain
// Holds one word; loads from the neighbor above on a push and from the
// neighbor below on a pop.
// ============================================================================
module smeu_data_cell (
    input  logic               clk,
    input  smeu_pkg::cell_ctl_t ctl,
    input  smeu_pkg::word_t    up_word,
    input  smeu_pkg::word_t    down_word,
    output smeu_pkg::word_t    word
);
    import smeu_pkg::*;

    word_t word_reg;

    // Shift in from a neighbor, else hold
    always_ff @(posedge clk)
    begin
        if (ctl.take_up)
        begin
            word_reg <= up_word;
        end
        else if (ctl.take_down)
        begin
            word_reg <= down_word;
        end
    end

    assign word = word_reg;

endmodule

@@ rtl/smeu_ret_cell.sv @@
// ============================================================================
// smeu_ret_cell: one entry of the return address chain
// Holds one instruction pointer; loads from the neighbor above on a call and
// from the neighbor below on a return.
// ============================================================================
module smeu_ret_cell (
    input  logic               clk,
    input  smeu_pkg::cell_ctl_t ctl,
    input  smeu_pkg::ip_t      up_addr,
    input  smeu_pkg::ip_t      down_addr,
    output smeu_pkg::ip_t      addr
);
    import smeu_pkg::*;

    ip_t addr_reg;

    // Shift in from a neighbor, else hold
    always_ff @(posedge clk)
    begin
        if (ctl.take_up)
        begin
            addr_reg <= up_addr;
        end
        else if (ctl.take_down)
        begin
            addr_reg <= down_addr;
        end
    end

    assign addr = addr_reg;

endmodule

@@ rtl/stack_machine_execute_unit.sv @@
// ============================================================================
// stack_machine_execute_unit: one stack-machine instruction per word
// Keeps the instruction pointer, a data stack and a return stack as chains of
// shift cells, and a variable store in RAM with per-slot written flags.
//
//   Channel  Dir  Handshake      Payload
//   instr    in   valid/ready    action, immediate, var_index, target, found
//   result   out  valid/ready    next_ip, top_value, top_valid, print_valid,
//                                status, done_res
//   cfg      in   cfg_we         cfg_wdata = program_length
//
// Two stages: the first registers the instruction and reads the variable RAM,
// the second executes against the stack cells and fills the output register.
// Sustained rate is one instruction per cycle while results are taken; an
// instruction passes the stage-one register, then the output register. A
// stalled result register stops the execute stage while the first stage still
// holds one more word. Reset clears the pointer, depths, halt flag and written
// flags at once; there is no clearing pass.
// ============================================================================
module stack_machine_execute_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    smeu_instr_if.sink                 instr,
    smeu_result_if.source              result,
    input  logic                       cfg_we,
    input  logic [smeu_pkg::IP_W-1:0]  cfg_wdata
);
    import smeu_pkg::*;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    ip_t                  cfg_len_reg;
    ip_t                  len_eff;

    logic                 a_valid_reg;
    logic [ACT_W-1:0]     a_action_reg;
    word_t                a_imm_reg;
    logic [VIDX_W-1:0]    a_vidx_reg;
    logic [TGT_W-1:0]     a_target_reg;
    logic                 a_found_reg;

    logic                 in_accept;
    logic                 advance;

    ip_t                  ip_reg;
    logic [DEPTH_W-1:0]   depth_reg;
    logic [DEPTH_W-1:0]   depth_next;
    logic [RDEPTH_W-1:0]  rdepth_reg;
    logic [RDEPTH_W-1:0]  rdepth_next;
    logic                 halted_reg;
    logic [VAR_COUNT-1:0] var_written_reg;

    logic                 fwd_valid_reg;
    logic [VAR_AW-1:0]    fwd_addr_reg;
    word_t                fwd_data_reg;

    word_t                data_q [STACK_DEPTH];
    ip_t                  ret_q  [CALL_DEPTH];

    logic [VAR_AW-1:0]    a_var_addr;
    logic                 var_in_range;
    word_t                ram_rdata;
    word_t                load_val;
    word_t                alu_val;
    word_t                new_top;
    word_t                top_after;
    ip_t                  step_ip;
    ip_t                  next_ip;
    logic [STAT_W-1:0]    status;
    logic                 printed;
    logic                 set_halt;
    logic                 var_we;
    logic                 cond_pos;
    stk_op_t              stk_op;
    stk_op_t              ret_op;

    logic                 out_valid_reg;
    ip_t                  out_ip_reg;
    word_t                out_top_reg;
    logic                 out_top_valid_reg;
    logic                 out_print_reg;
    logic [STAT_W-1:0]    out_status_reg;
    logic                 out_done_reg;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign advance     = a_valid_reg && (!out_valid_reg || result.ready);
    assign instr.ready = !a_valid_reg || advance;
    assign in_accept   = instr.valid && instr.ready;

    // Program length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_len_reg <= '0;
        end
        else if (cfg_we)
        begin
            cfg_len_reg <= cfg_wdata;
        end
    end

    // Clip the length to the program depth
    assign len_eff = (32'(cfg_len_reg) < PROG_DEPTH) ? cfg_len_reg : IP_W'(PROG_DEPTH);

    // ------------------------------------------------------------------
    // Stage one: capture the instruction word
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (instr.ready)
        begin
            a_valid_reg <= instr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_action_reg <= instr.action;
            a_imm_reg    <= instr.immediate;
            a_vidx_reg   <= instr.var_index;
            a_target_reg <= instr.target;
            a_found_reg  <= instr.target_found;
        end
    end

    // Variable store, read as the word enters
    smeu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (VAR_COUNT)
    ) u_var_ram (
        .clk   (clk),
        .we    (advance && var_we),
        .waddr (a_var_addr),
        .wdata (data_q[0]),
        .re    (in_accept),
        .raddr (VAR_AW'(instr.var_index)),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage two: execute
    // ------------------------------------------------------------------
    assign a_var_addr   = VAR_AW'(a_vidx_reg);
    assign var_in_range = 32'(a_vidx_reg) < VAR_COUNT;

    // Bypass a store that executed as this word was read
    assign load_val = (fwd_valid_reg && fwd_addr_reg == a_var_addr) ? fwd_data_reg
                                                                    : ram_rdata;

    assign cond_pos = (data_q[0] != '0) && !data_q[0][WORD_W-1];
    assign step_ip  = sat_inc(ip_reg, 2'd1);

    // Arithmetic on the two top entries
    always_comb
    begin
        unique case (a_action_reg)
            OP_ADD:  alu_val = data_q[1] + data_q[0];
            OP_SUB:  alu_val = data_q[1] - data_q[0];
            default: alu_val = data_q[1] * data_q[0];
        endcase
    end

    // Decode the instruction against the current state
    always_comb
    begin
        status   = ST_OK;
        next_ip  = ip_reg;
        stk_op   = STK_HOLD;
        ret_op   = STK_HOLD;
        new_top  = a_imm_reg;
        printed  = 1'b0;
        var_we   = 1'b0;
        set_halt = 1'b0;
        if (halted_reg)
        begin
            status = ST_HALTED;
        end
        else if (ip_reg < len_eff)
        begin
            next_ip = step_ip;
            unique case (a_action_reg)
                OP_PUSH:
                begin
                    if (depth_reg == DEPTH_W'(STACK_DEPTH))
                    begin
                        status = ST_OVERFLOW;
                    end
                    else
                    begin
                        stk_op = STK_PUSH;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL:
                begin
                    if (depth_reg < DEPTH_W'(2))
                    begin
                        status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        stk_op  = STK_MERGE;
                        new_top = alu_val;
                    end
                end
                OP_STORE:
                begin
                    if (depth_reg == '0)
                    begin
                        status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        stk_op = STK_POP;
                        var_we = var_in_range;
                    end
                end
                OP_LOAD:
                begin
                    if (!var_in_range || !var_written_reg[a_var_addr])
                    begin
                        status = ST_VAR_UNK;
                    end
                    else if (depth_reg == DEPTH_W'(STACK_DEPTH))
                    begin
                        status = ST_OVERFLOW;
                    end
                    else
                    begin
                        stk_op  = STK_PUSH;
                        new_top = load_val;
                    end
                end
                OP_IF:
                begin
                    if (depth_reg == '0)
                    begin
                        status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        stk_op = STK_POP;
                        if (!cond_pos)
                        begin
                            next_ip = sat_inc(ip_reg, 2'd2);
                        end
                    end
                end
                OP_GOTO:
                begin
                    if (!a_found_reg)
                    begin
                        status = ST_LABEL_UNK;
                    end
                    else
                    begin
                        next_ip = IP_W'(a_target_reg);
                    end
                end
                OP_FUNC:
                begin
                end
                OP_CALL:
                begin
                    if (!a_found_reg)
                    begin
                        status = ST_LABEL_UNK;
                    end
                    else if (rdepth_reg == RDEPTH_W'(CALL_DEPTH))
                    begin
                        status = ST_OVERFLOW;
                    end
                    else
                    begin
                        ret_op  = STK_PUSH;
                        next_ip = sat_inc(IP_W'(a_target_reg), 2'd1);
                    end
                end
                OP_RET:
                begin
                    if (rdepth_reg == '0)
                    begin
                        status = ST_RET_EMPTY;
                    end
                    else
                    begin
                        ret_op  = STK_POP;
                        next_ip = ret_q[0];
                    end
                end
                OP_PRINT:
                begin
                    printed = depth_reg != '0;
                end
                default:
                begin
                    status = ST_BAD_OP;
                end
            endcase
            // Drop every change on an error and halt
            if (status != ST_OK)
            begin
                next_ip  = ip_reg;
                stk_op   = STK_HOLD;
                ret_op   = STK_HOLD;
                var_we   = 1'b0;
                set_halt = 1'b1;
            end
        end
    end

    // Top of stack and depths after the step
    always_comb
    begin
        unique case (stk_op)
            STK_HOLD:
            begin
                top_after  = data_q[0];
                depth_next = depth_reg;
            end
            STK_PUSH:
            begin
                top_after  = new_top;
                depth_next = depth_reg + DEPTH_W'(1);
            end
            STK_POP:
            begin
                top_after  = data_q[1];
                depth_next = depth_reg - DEPTH_W'(1);
            end
            default:
            begin
                top_after  = new_top;
                depth_next = depth_reg - DEPTH_W'(1);
            end
        endcase
        unique case (ret_op)
            STK_PUSH: rdepth_next = rdepth_reg + RDEPTH_W'(1);
            STK_POP:  rdepth_next = rdepth_reg - RDEPTH_W'(1);
            default:  rdepth_next = rdepth_reg;
        endcase
    end

    // Architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_reg          <= '0;
            depth_reg       <= '0;
            rdepth_reg      <= '0;
            halted_reg      <= 1'b0;
            var_written_reg <= '0;
            fwd_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            ip_reg        <= next_ip;
            depth_reg     <= depth_next;
            rdepth_reg    <= rdepth_next;
            halted_reg    <= halted_reg || set_halt;
            fwd_valid_reg <= var_we;
            if (var_we)
            begin
                var_written_reg[a_var_addr] <= 1'b1;
            end
        end
    end

    // Last store, for the bypass
    always_ff @(posedge clk)
    begin
        if (advance && var_we)
        begin
            fwd_addr_reg <= a_var_addr;
            fwd_data_reg <= data_q[0];
        end
    end

    // ------------------------------------------------------------------
    // Data stack: chain of cells, entry zero on top
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < STACK_DEPTH; gi++)
    begin : g_data
        cell_ctl_t ctl;
        word_t     up_word;
        word_t     down_word;

        assign ctl.take_up   = advance &&
                               (stk_op == STK_PUSH || (gi == 0 && stk_op == STK_MERGE));
        assign ctl.take_down = advance &&
                               (stk_op == STK_POP || (gi != 0 && stk_op == STK_MERGE));

        if (gi == 0)
        begin : g_top
            assign up_word = new_top;
        end
        else
        begin : g_mid
            assign up_word = data_q[gi-1];
        end

        if (gi == STACK_DEPTH - 1)
        begin : g_bot
            assign down_word = data_q[gi];
        end
        else
        begin : g_inner
            assign down_word = data_q[gi+1];
        end

        smeu_data_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .up_word   (up_word),
            .down_word (down_word),
            .word      (data_q[gi])
        );
    end

    // ------------------------------------------------------------------
    // Return stack: chain of cells, entry zero on top
    // ------------------------------------------------------------------
    for (genvar gr = 0; gr < CALL_DEPTH; gr++)
    begin : g_ret
        cell_ctl_t ctl;
        ip_t       up_addr;
        ip_t       down_addr;

        assign ctl.take_up   = advance && ret_op == STK_PUSH;
        assign ctl.take_down = advance && ret_op == STK_POP;

        if (gr == 0)
        begin : g_top
            assign up_addr = step_ip;
        end
        else
        begin : g_mid
            assign up_addr = ret_q[gr-1];
        end

        if (gr == CALL_DEPTH - 1)
        begin : g_bot
            assign down_addr = ret_q[gr];
        end
        else
        begin : g_inner
            assign down_addr = ret_q[gr+1];
        end

        smeu_ret_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .up_addr   (up_addr),
            .down_addr (down_addr),
            .addr      (ret_q[gr])
        );
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_ip_reg        <= next_ip;
            out_top_reg       <= (depth_next != '0) ? top_after : '0;
            out_top_valid_reg <= depth_next != '0;
            out_print_reg     <= printed;
            out_status_reg    <= status;
            out_done_reg      <= next_ip >= len_eff;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.next_ip     = out_ip_reg;
    assign result.top_value   = out_top_reg;
    assign result.top_valid   = out_top_valid_reg;
    assign result.print_valid = out_print_reg;
    assign result.status      = out_status_reg;
    assign result.done_res    = out_done_reg;

endmodule

@@ tb/tb_stack_machine_execute_unit.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_stack_machine_execute_unit: self-checking bench for the execute unit
// Drives instruction words through valid/ready with bursty gaps, stalls the
// result side on shifting patterns, and compares every result word against
// an in-bench model of the pointer, data stack, variables and return stack.
// Program length is rewritten between phases while the unit is idle; one
// randomly chosen fault ends the run and the halted behavior is checked.
// ============================================================================
module tb_stack_machine_execute_unit;
    import smeu_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [WORD_W-1:0] immediate;
        logic [VIDX_W-1:0] var_index;
        logic [TGT_W-1:0]  target;
        logic              target_found;
    } instr_word_t;

    typedef struct {
        ip_t               next_ip;
        word_t             top_value;
        logic              top_valid;
        logic              print_valid;
        logic [STAT_W-1:0] status;
        logic              done_res;
    } result_word_t;

    typedef enum {MIX_BALANCED, MIX_FILL, MIX_NEST, MIX_EMPTY} mix_t;

    typedef enum {
        FAULT_UNDERFLOW, FAULT_STACK_FULL, FAULT_LOAD_FULL, FAULT_CALL_FULL,
        FAULT_GOTO_LABEL, FAULT_CALL_LABEL, FAULT_RET_EMPTY, FAULT_BAD_OP
    } fault_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [IP_W-1:0]     cfg_wdata;

    smeu_instr_if  instr_ch ();
    smeu_result_if result_ch ();

    stack_machine_execute_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .instr     (instr_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Model state of the unit
    int          prog_len = 0;
    int          pc = 0;
    bit          is_halted = 0;
    bit [31:0]   stk_mem [STACK_DEPTH];
    int          stk_depth = 0;
    bit [31:0]   var_mem [VAR_COUNT];
    bit          var_set [VAR_COUNT];
    int          n_var_set = 0;
    int          ret_mem [CALL_DEPTH];
    int          ret_depth = 0;

    result_word_t pending_results [$];
    int           mismatches = 0;
    int           burst_left = 0;
    bit           sender_steady = 0;
    bit           hold_req = 0;
    int           idle_cycles = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int eff_len();
        return (prog_len < PROG_DEPTH) ? prog_len : PROG_DEPTH;
    endfunction

    function automatic int bump_ip(input int v, input int n);
        return (v + n > IP_MAX) ? IP_MAX : v + n;
    endfunction

    // Execute one word on the model and return the result word it causes
    function automatic result_word_t execute_step(input instr_word_t w);
        result_word_t      r;
        logic [STAT_W-1:0] st;
        int                nxt;
        bit                shown;
        bit [31:0]         a;
        bit [31:0]         b;
        bit [31:0]         c;
        st = ST_OK;
        shown = 0;
        nxt = pc;
        if (is_halted)
            st = ST_HALTED;
        else if (pc < eff_len())
        begin
            nxt = bump_ip(pc, 1);
            case (w.action)
                OP_PUSH:
                    if (stk_depth >= STACK_DEPTH)
                        st = ST_OVERFLOW;
                    else
                    begin
                        stk_mem[stk_depth] = w.immediate;
                        stk_depth++;
                    end
                OP_ADD, OP_SUB, OP_MUL:
                    if (stk_depth < 2)
                        st = ST_UNDERFLOW;
                    else
                    begin
                        b = stk_mem[stk_depth-1];
                        a = stk_mem[stk_depth-2];
                        stk_depth--;
                        stk_mem[stk_depth-1] = (w.action == OP_ADD) ? a + b :
                                               (w.action == OP_SUB) ? a - b : a * b;
                    end
                OP_STORE:
                    if (stk_depth < 1)
                        st = ST_UNDERFLOW;
                    else
                    begin
                        stk_depth--;
                        var_mem[w.var_index] = stk_mem[stk_depth];
                        if (!var_set[w.var_index])
                            n_var_set++;
                        var_set[w.var_index] = 1;
                    end
                OP_LOAD:
                    if (!var_set[w.var_index])
                        st = ST_VAR_UNK;
                    else if (stk_depth >= STACK_DEPTH)
                        st = ST_OVERFLOW;
                    else
                    begin
                        stk_mem[stk_depth] = var_mem[w.var_index];
                        stk_depth++;
                    end
                OP_IF:
                    if (stk_depth < 1)
                        st = ST_UNDERFLOW;
                    else
                    begin
                        stk_depth--;
                        c = stk_mem[stk_depth];
                        if ($signed(c) <= 0)
                            nxt = bump_ip(pc, 2);
                    end
                OP_GOTO:
                    if (!w.target_found)
                        st = ST_LABEL_UNK;
                    else
                        nxt = int'(w.target);
                OP_FUNC:
                    ;
                OP_CALL:
                    if (!w.target_found)
                        st = ST_LABEL_UNK;
                    else if (ret_depth >= CALL_DEPTH)
                        st = ST_OVERFLOW;
                    else
                    begin
                        ret_mem[ret_depth] = bump_ip(pc, 1);
                        ret_depth++;
                        nxt = bump_ip(int'(w.target), 1);
                    end
                OP_RET:
                    if (ret_depth == 0)
                        st = ST_RET_EMPTY;
                    else
                    begin
                        ret_depth--;
                        nxt = ret_mem[ret_depth];
                    end
                OP_PRINT:
                    shown = (stk_depth > 0);
                default:
                    st = ST_BAD_OP;
            endcase
            // A fault leaves everything but the halt flag untouched
            if (st != ST_OK)
            begin
                is_halted = 1;
                nxt = pc;
            end
            else
                pc = nxt;
        end
        r.next_ip     = ip_t'(nxt);
        r.top_value   = (stk_depth > 0) ? stk_mem[stk_depth-1] : '0;
        r.top_valid   = (stk_depth > 0);
        r.print_valid = shown;
        r.status      = st;
        r.done_res    = (nxt >= eff_len());
        return r;
    endfunction

    // Pick a slot that holds a stored value
    function automatic logic [VIDX_W-1:0] written_slot();
        logic [VIDX_W-1:0] s;
        do
            s = VIDX_W'($urandom_range(0, VAR_COUNT - 1));
        while (!var_set[s]);
        return s;
    endfunction

    // Random payload around a given action; loads only touch stored slots
    function automatic instr_word_t random_fields(input logic [ACT_W-1:0] act);
        instr_word_t w;
        w.action = act;
        case ($urandom_range(0, 7))
            0: w.immediate = 32'h8000_0000;
            1: w.immediate = 32'h7FFF_FFFF;
            2: w.immediate = 32'h0000_0000;
            3: w.immediate = 32'hFFFF_FFFF;
            4: w.immediate = $urandom_range(0, 15);
            default: w.immediate = $urandom;
        endcase
        w.var_index    = VIDX_W'($urandom_range(0, VAR_COUNT - 1));
        w.target       = TGT_W'($urandom_range(0, (1 << TGT_W) - 1));
        w.target_found = 1'($urandom_range(0, 1));
        if (act == OP_LOAD)
        begin
            if (n_var_set > 0)
                w.var_index = written_slot();
            else
                w.action = OP_FUNC;
        end
        return w;
    endfunction

    // True if the action runs without a fault in the current state
    function automatic bit can_issue(input logic [ACT_W-1:0] op);
        case (op)
            OP_PUSH:                return stk_depth < STACK_DEPTH;
            OP_ADD, OP_SUB, OP_MUL: return stk_depth >= 2;
            OP_STORE, OP_IF:        return stk_depth >= 1;
            OP_LOAD:                return stk_depth < STACK_DEPTH && n_var_set > 0;
            OP_CALL:                return ret_depth < CALL_DEPTH;
            OP_RET:                 return ret_depth > 0 && ret_mem[ret_depth-1] < eff_len();
            OP_GOTO, OP_FUNC, OP_PRINT: return 1;
            default:                return 0;
        endcase
    endfunction

    // Fault-free word for an action, with labels kept inside the program
    function automatic instr_word_t build_word(input logic [ACT_W-1:0] op);
        instr_word_t w;
        w = random_fields(op);
        if (op == OP_GOTO || op == OP_CALL)
        begin
            w.target_found = 1;
            w.target = TGT_W'($urandom_range(0, eff_len() - ((op == OP_CALL) ? 2 : 1)));
        end
        return w;
    endfunction

    function automatic logic [ACT_W-1:0] pick_op(input mix_t mode);
        logic [ACT_W-1:0] op;
        int               r;
        do
        begin
            r = $urandom_range(0, 99);
            if (r < 60 && mode == MIX_FILL)
                op = ($urandom_range(0, 3) == 0) ? OP_LOAD : OP_PUSH;
            else if (r < 60 && mode == MIX_NEST)
                op = ($urandom_range(0, 3) == 0) ? OP_RET : OP_CALL;
            else if (r < 60 && mode == MIX_EMPTY)
            begin
                case ($urandom_range(0, 4))
                    0: op = OP_ADD;
                    1: op = OP_SUB;
                    2: op = OP_MUL;
                    3: op = OP_STORE;
                    default: op = OP_IF;
                endcase
            end
            else
                op = ACT_W'($urandom_range(0, OP_PRINT));
        end
        while (!can_issue(op));
        return op;
    endfunction

    // Offer one word, with a random gap between bursts, and record its result
    task automatic send_instr(input instr_word_t w);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = sender_steady ? 0 :
                  (($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0);
            if (gap > 0)
            begin
                instr_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        instr_ch.valid        <= 1'b1;
        instr_ch.action       <= w.action;
        instr_ch.immediate    <= w.immediate;
        instr_ch.var_index    <= w.var_index;
        instr_ch.target       <= w.target;
        instr_ch.target_found <= w.target_found;
        do
            @(posedge clk);
        while (instr_ch.ready !== 1'b1);
        pending_results.insert(pending_results.size(), execute_step(w));
    endtask

    task automatic send_op(input logic [ACT_W-1:0] op, input logic [WORD_W-1:0] imm,
                           input int slot, input int tgt);
        instr_word_t w;
        w.action       = op;
        w.immediate    = imm;
        w.var_index    = VIDX_W'(slot);
        w.target       = TGT_W'(tgt);
        w.target_found = 1'b1;
        send_instr(w);
    endtask

    // Jump back near the start before the pointer runs off the program
    task automatic keep_in_program();
        instr_word_t w;
        if (!is_halted && pc + 4 > eff_len())
        begin
            w = random_fields(OP_GOTO);
            w.target_found = 1'b1;
            w.target = TGT_W'($urandom_range(0, eff_len() / 4));
            send_instr(w);
        end
    endtask

    // Drop valid and wait for every outstanding result word
    task automatic wait_idle();
        @(negedge clk);
        instr_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (4) @(negedge clk);
    endtask

    // Move the pointer low if needed, drain, then rewrite the program length
    task automatic new_length(input int len);
        int lim;
        lim = (len < PROG_DEPTH) ? len : PROG_DEPTH;
        if (!is_halted && pc < eff_len() && pc + 4 > lim)
            send_op(OP_GOTO, '0, 0, 0);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= IP_W'(len);
        @(negedge clk);
        cfg_we    <= 1'b0;
        prog_len = len;
    endtask

    task automatic run_random(input int count, input mix_t mode);
        repeat (count)
        begin
            keep_in_program();
            send_instr(build_word(pick_op(mode)));
        end
    endtask

    // Length zero after reset: every word is past the end
    task automatic test_reset_state();
        repeat (4) send_instr(random_fields(ACT_W'($urandom_range(0, 15))));
    endtask

    // Extremes of the arithmetic, variables, branches and calls
    task automatic test_basic_ops();
        new_length(PROG_DEPTH);
        send_op(OP_PUSH, 32'h7FFF_FFFF, 0, 0);
        send_op(OP_PUSH, 32'd1, 0, 0);
        send_op(OP_ADD, '0, 0, 0);
        send_op(OP_PUSH, 32'hFFFF_FFFF, 0, 0);
        send_op(OP_MUL, '0, 0, 0);
        send_op(OP_PUSH, 32'd1, 0, 0);
        send_op(OP_SUB, '0, 0, 0);
        send_op(OP_STORE, '0, VAR_COUNT - 1, 0);
        // print with nothing on the stack
        send_op(OP_PRINT, '0, 0, 0);
        send_op(OP_LOAD, '0, VAR_COUNT - 1, 0);
        send_op(OP_STORE, '0, 0, 0);
        send_op(OP_LOAD, '0, 0, 0);
        send_op(OP_PRINT, '0, 0, 0);
        // zero and negative conditions skip, positive falls through
        send_op(OP_PUSH, 32'd0, 0, 0);
        send_op(OP_IF, '0, 0, 0);
        send_op(OP_PUSH, 32'h8000_0000, 0, 0);
        send_op(OP_IF, '0, 0, 0);
        send_op(OP_PUSH, 32'd1, 0, 0);
        send_op(OP_IF, '0, 0, 0);
        send_op(OP_FUNC, '0, 0, 0);
        send_op(OP_CALL, '0, 0, 500);
        send_op(OP_RET, '0, 0, 0);
        send_op(OP_GOTO, '0, 0, (1 << TGT_W) - 1);
        send_op(OP_GOTO, '0, 0, 0);
    endtask

    // Run off a short program, check ignored words, then extend it
    task automatic test_program_end();
        new_length(3);
        repeat (3) send_op(OP_FUNC, '0, 0, 0);
        repeat (3) send_instr(random_fields(ACT_W'($urandom_range(0, 15))));
        new_length((1 << IP_W) - 1);
    endtask

    task automatic test_random_mix();
        int   len;
        mix_t mode;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: len = $urandom_range(8, 64);
                1: len = PROG_DEPTH;
                2: len = (1 << IP_W) - 1;
                default: len = $urandom_range(8, (1 << IP_W) - 1);
            endcase
            mode = mix_t'(ph % 4);
            new_length(len);
            sender_steady = (ph == 2);
            // back up the pipeline once with a long receiver hold
            if (ph == 3)
                hold_req = 1;
            run_random(165, mode);
        end
        sender_steady = 0;
    endtask

    // Drive into one fault, then check that later words report halted
    task automatic test_fault();
        fault_t      kind;
        instr_word_t w;
        kind = fault_t'($urandom_range(0, 7));
        new_length(PROG_DEPTH);
        case (kind)
            FAULT_UNDERFLOW:
            begin
                while (stk_depth > 0)
                begin
                    keep_in_program();
                    send_instr(build_word(OP_STORE));
                end
                keep_in_program();
                case ($urandom_range(0, 4))
                    0: w = random_fields(OP_ADD);
                    1: w = random_fields(OP_SUB);
                    2: w = random_fields(OP_MUL);
                    3: w = random_fields(OP_STORE);
                    default: w = random_fields(OP_IF);
                endcase
                send_instr(w);
            end
            FAULT_STACK_FULL, FAULT_LOAD_FULL:
            begin
                while (stk_depth < STACK_DEPTH)
                begin
                    keep_in_program();
                    send_instr(build_word(OP_PUSH));
                end
                keep_in_program();
                send_instr(random_fields((kind == FAULT_LOAD_FULL) ? OP_LOAD : OP_PUSH));
            end
            FAULT_CALL_FULL:
            begin
                while (ret_depth < CALL_DEPTH)
                begin
                    keep_in_program();
                    send_instr(build_word(OP_CALL));
                end
                keep_in_program();
                send_instr(build_word(OP_CALL));
            end
            FAULT_RET_EMPTY:
            begin
                while (ret_depth > 0)
                begin
                    keep_in_program();
                    send_instr(build_word(OP_RET));
                end
                keep_in_program();
                send_instr(random_fields(OP_RET));
            end
            FAULT_GOTO_LABEL, FAULT_CALL_LABEL:
            begin
                keep_in_program();
                w = random_fields((kind == FAULT_GOTO_LABEL) ? OP_GOTO : OP_CALL);
                w.target_found = 1'b0;
                send_instr(w);
            end
            default:
            begin
                keep_in_program();
                send_instr(random_fields(ACT_W'($urandom_range(OP_PRINT + 1, 15))));
            end
        endcase
        repeat (12) send_instr(random_fields(ACT_W'($urandom_range(0, 15))));
    endtask

    // Stimulus and final verdict
    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        instr_ch.valid        = 1'b0;
        instr_ch.action       = '0;
        instr_ch.immediate    = '0;
        instr_ch.var_index    = '0;
        instr_ch.target       = '0;
        instr_ch.target_found = 1'b0;
        for (int i = 0; i < VAR_COUNT; i++)
            var_set[i] = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_basic_ops();
        test_program_end();
        test_random_mix();
        test_fault();

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side: stall patterns that change every span, plus one long hold
    initial
    begin
        int  mode;
        int  span;
        int  per;
        int  cyc;
        bit  rdy;
        result_ch.ready = 1'b0;
        cyc = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            per  = $urandom_range(1, 6);
            repeat (span)
            begin
                @(negedge clk);
                if (hold_req)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_req = 0;
                end
                cyc++;
                case (mode)
                    0: rdy = 1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = ($urandom_range(0, 7) != 0);
                    default: rdy = ((cyc / per) % 2) == 0;
                endcase
                result_ch.ready <= rdy;
            end
        end
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge clk)
    begin
        result_word_t exp;
        if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no expected word pending");
                mismatches++;
            end
            else
            begin
                exp = pending_results.pop_front();
                if (result_ch.next_ip !== exp.next_ip)
                begin
                    $error("next_ip: expected %0d, got %0d", exp.next_ip, result_ch.next_ip);
                    mismatches++;
                end
                if (result_ch.top_value !== exp.top_value)
                begin
                    $error("top_value: expected %h, got %h", exp.top_value, result_ch.top_value);
                    mismatches++;
                end
                if (result_ch.top_valid !== exp.top_valid)
                begin
                    $error("top_valid: expected %b, got %b", exp.top_valid, result_ch.top_valid);
                    mismatches++;
                end
                if (result_ch.print_valid !== exp.print_valid)
                begin
                    $error("print_valid: expected %b, got %b",
                           exp.print_valid, result_ch.print_valid);
                    mismatches++;
                end
                if (result_ch.status !== exp.status)
                begin
                    $error("status: expected %0d, got %0d", exp.status, result_ch.status);
                    mismatches++;
                end
                if (result_ch.done_res !== exp.done_res)
                begin
                    $error("done_res: expected %b, got %b", exp.done_res, result_ch.done_res);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge clk)
    begin
        if ((instr_ch.valid === 1'b1 && instr_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule
